// File: sv/stable_sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable sorted priority queue
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_DEFINES_SVH

// antecedent holds now, consequent holds on the next edge
`define SSQ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// antecedent and consequent on the same edge
`define SSQ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/ssq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_pkg
// Command and status codes and the control struct for the queue cells.
// ----------------------------------------------------------------------------
package ssq_pkg;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PEEK   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic ins;
    logic rem;
  } ssq_ctrl_t;

endpackage

// File: sv/ssq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_cell
// One slot of the sorted chain: holds an entry, keeps it, takes the new
// entry, or takes a neighbour's entry on insert and remove.
// ----------------------------------------------------------------------------
module ssq_cell #(
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16,
  parameter int CNT_W         = 5,
  parameter int INDEX         = 0
) (
  input  logic                            clk,
  input  ssq_pkg::ssq_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                count,
  input  logic [PAYLOAD_BITS-1:0]         new_pay,
  input  logic signed [PRIORITY_BITS-1:0] new_pri,
  input  logic                            left_keep,
  input  logic [PAYLOAD_BITS-1:0]         left_pay,
  input  logic signed [PRIORITY_BITS-1:0] left_pri,
  input  logic [PAYLOAD_BITS-1:0]         right_pay,
  input  logic signed [PRIORITY_BITS-1:0] right_pri,
  output logic                            keep,
  output logic [PAYLOAD_BITS-1:0]         pay,
  output logic signed [PRIORITY_BITS-1:0] pri
);
  import ssq_pkg::*;

  localparam logic [CNT_W-1:0] MY_INDEX = CNT_W'(INDEX);

  logic                            occupied;
  logic [PAYLOAD_BITS-1:0]         pay_next;
  logic signed [PRIORITY_BITS-1:0] pri_next;

  // an equal priority stays ahead of the newcomer
  assign occupied = count > MY_INDEX;
  assign keep     = occupied && (pri >= new_pri);

  always_comb begin
    pay_next = pay;
    pri_next = pri;
    if (ctrl.ins && !keep) begin
      if (left_keep) begin
        pay_next = new_pay;
        pri_next = new_pri;
      end else begin
        pay_next = left_pay;
        pri_next = left_pri;
      end
    end else if (ctrl.rem) begin
      pay_next = right_pay;
      pri_next = right_pri;
    end
  end

  always_ff @(posedge clk) begin
    pay <= pay_next;
    pri <= pri_next;
  end

endmodule

// File: sv/stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
// Result: a command's result is shown with done in the cycle after start.
// Throughput: one command per cycle; busy stays low, as every cell settles
// its slot from its own compare and its neighbours.
// Reset: rst (synchronous) empties the queue and clears done; slot contents
// are not cleared, since only slots below the entry count are ever read.
// ----------------------------------------------------------------------------
// stable_sorted_priority_queue
// Bounded priority queue built as a shifting chain of cells, highest
// priority at the head, first in first out among equal priorities.
// ----------------------------------------------------------------------------
module stable_sorted_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ssq_pkg::CMD_W-1:0]       command,
  input  logic [PAYLOAD_BITS-1:0]         payload,
  input  logic signed [PRIORITY_BITS-1:0] priority_req,
  output logic                            done,
  output logic [ssq_pkg::STATUS_W-1:0]    status,
  output logic [PAYLOAD_BITS-1:0]         head_payload,
  output logic signed [PRIORITY_BITS-1:0] head_priority,
  output logic [$clog2(DEPTH+1)-1:0]      entry_count,
  output logic                            is_empty
);
  import ssq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic                            accept;
  logic                            is_ins;
  logic                            is_rem;
  logic                            full;
  logic                            empty;
  ssq_ctrl_t                       ctrl;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                count_next;

  logic                            keep_w [DEPTH];
  logic [PAYLOAD_BITS-1:0]         pay_w  [DEPTH];
  logic signed [PRIORITY_BITS-1:0] pri_w  [DEPTH];

  logic [STATUS_W-1:0]             status_next;
  logic [PAYLOAD_BITS-1:0]         head_pay_next;
  logic signed [PRIORITY_BITS-1:0] head_pri_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign is_ins = command == CMD_INSERT;
  assign is_rem = command == CMD_REMOVE;
  assign full   = count == FULL_COUNT;
  assign empty  = count == '0;

  assign ctrl.ins = accept && is_ins && !full;
  assign ctrl.rem = accept && is_rem && !empty;

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic                            lk;
      logic [PAYLOAD_BITS-1:0]         lpay;
      logic signed [PRIORITY_BITS-1:0] lpri;
      logic [PAYLOAD_BITS-1:0]         rpay;
      logic signed [PRIORITY_BITS-1:0] rpri;

      if (g == 0) begin : g_head
        assign lk   = 1'b1;
        assign lpay = '0;
        assign lpri = '0;
      end else begin : g_body
        assign lk   = keep_w[g-1];
        assign lpay = pay_w[g-1];
        assign lpri = pri_w[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
        assign rpay = '0;
        assign rpri = '0;
      end else begin : g_mid
        assign rpay = pay_w[g+1];
        assign rpri = pri_w[g+1];
      end

      ssq_cell #(
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .PRIORITY_BITS(PRIORITY_BITS),
        .CNT_W        (CNT_W),
        .INDEX        (g)
      ) u_cell (
        .clk      (clk),
        .ctrl     (ctrl),
        .count    (count),
        .new_pay  (payload),
        .new_pri  (priority_req),
        .left_keep(lk),
        .left_pay (lpay),
        .left_pri (lpri),
        .right_pay(rpay),
        .right_pri(rpri),
        .keep     (keep_w[g]),
        .pay      (pay_w[g]),
        .pri      (pri_w[g])
      );
    end
  endgenerate

  always_comb begin
    count_next = count;
    if (ctrl.ins) begin
      count_next = count + 1'b1;
    end else if (ctrl.rem) begin
      count_next = count - 1'b1;
    end
  end

  // head after the command; a remove shows the entry it takes off
  always_comb begin
    status_next   = ST_DONE;
    head_pay_next = pay_w[0];
    head_pri_next = pri_w[0];
    if (is_ins) begin
      if (full) begin
        status_next = ST_FULL;
      end else if (!keep_w[0]) begin
        head_pay_next = payload;
        head_pri_next = priority_req;
      end
    end else if (empty) begin
      status_next   = ST_EMPTY;
      head_pay_next = '0;
      head_pri_next = '0;
    end else if (is_rem && count == CNT_W'(1)) begin
      // last entry leaves: still shown, count drops to zero
      head_pay_next = pay_w[0];
      head_pri_next = pri_w[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      head_payload  <= head_pay_next;
      head_priority <= head_pri_next;
      entry_count   <= count_next;
      is_empty      <= count_next == '0;
    end
  end

endmodule

// File: sv/ssq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssq_checker
// Port-level checks on the queue: result timing and result consistency.
// ----------------------------------------------------------------------------
`include "stable_sorted_priority_queue_defines.svh"

module ssq_checker #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_BITS  = 32,
  parameter int PRIORITY_BITS = 16
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic                            done,
  input logic [ssq_pkg::STATUS_W-1:0]    status,
  input logic [PAYLOAD_BITS-1:0]         head_payload,
  input logic signed [PRIORITY_BITS-1:0] head_priority,
  input logic [$clog2(DEPTH+1)-1:0]      entry_count,
  input logic                            is_empty
);
  import ssq_pkg::*;

  `SSQ_ASSERT_NEXT(a_result_follows, clk, rst, start && !busy, done)
  `SSQ_ASSERT_NEXT(a_no_spurious, clk, rst, !(start && !busy), !done)
  `SSQ_ASSERT_NOW(a_empty_flag, clk, rst, done, is_empty == (entry_count == '0))
  `SSQ_ASSERT_NOW(a_empty_status, clk, rst, done && status == ST_EMPTY, head_payload == '0 && head_priority == '0 && is_empty)
  `SSQ_ASSERT_NOW(a_full_count, clk, rst, done && status == ST_FULL, entry_count == ($clog2(DEPTH+1))'(DEPTH))

endmodule

bind stable_sorted_priority_queue ssq_checker #(
  .DEPTH        (DEPTH),
  .PAYLOAD_BITS (PAYLOAD_BITS),
  .PRIORITY_BITS(PRIORITY_BITS)
) u_ssq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .head_payload (head_payload),
  .head_priority(head_priority),
  .entry_count  (entry_count),
  .is_empty     (is_empty)
);

// File: verif/tb_stable_sorted_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_sorted_priority_queue
// Self-checking bench for the sorted priority queue. A directed run covers
// the empty queue, extreme priorities and payloads, ties and the spare
// command code. Fill, drain and mixed phases of random commands follow. A
// behavioural copy of the queue predicts every result, and each result is
// checked against it field by field in order.
// ----------------------------------------------------------------------------
module tb_stable_sorted_priority_queue;
  import ssq_pkg::*;

  localparam int SLOTS     = 16;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int IDLE_MAX  = 2000;
  localparam int TAIL_WAIT = 8;
  // spare code, handled as a peek
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  typedef struct {
    logic [CMD_W-1:0]   cmd;
    logic [31:0]        pay;
    logic signed [15:0] prio;
    bit                 hold;  // wait until every result is back before sending
  } cmd_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [31:0]         pay;
    logic signed [15:0]  prio;
    logic [CNT_W-1:0]    count;
    logic                empty;
  } queue_result_t;

  bit                  clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic [CMD_W-1:0]    command = CMD_PEEK;
  logic [31:0]         payload = '0;
  logic signed [15:0]  priority_req = '0;
  logic                busy;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [31:0]         head_payload;
  logic signed [15:0]  head_priority;
  logic [CNT_W-1:0]    entry_count;
  logic                is_empty;

  cmd_item_t     pending_cmds[$];
  queue_result_t expected_results[$];

  // behavioural copy of the queue contents
  logic signed [15:0] model_prio[SLOTS];
  logic [31:0]        model_pay[SLOTS];
  int                 model_held = 0;

  int errors       = 0;
  int issued       = 0;
  int total_cmds   = 0;
  int gap_left     = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  bit item_taken;
  cmd_item_t nxt;

  stable_sorted_priority_queue #(
    .DEPTH        (SLOTS),
    .PAYLOAD_BITS (32),
    .PRIORITY_BITS(16)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .payload      (payload),
    .priority_req (priority_req),
    .done         (done),
    .status       (status),
    .head_payload (head_payload),
    .head_priority(head_priority),
    .entry_count  (entry_count),
    .is_empty     (is_empty)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the copy and return the result it should give.
  function automatic queue_result_t predict_queue_result(logic [CMD_W-1:0] cmd,
                                                         logic [31:0] pay,
                                                         logic signed [15:0] prio);
    queue_result_t r;
    int pos;
    bit show;
    r.status = ST_DONE;
    show     = 1'b1;
    if (cmd == CMD_INSERT) begin
      if (model_held >= SLOTS) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < model_held && model_prio[pos] >= prio) pos++;
        for (int i = model_held; i > pos; i--) begin
          model_prio[i] = model_prio[i-1];
          model_pay[i]  = model_pay[i-1];
        end
        model_prio[pos] = prio;
        model_pay[pos]  = pay;
        model_held++;
      end
      r.pay  = model_pay[0];
      r.prio = model_prio[0];
      show   = (model_held != 0);
    end else if (model_held == 0) begin
      r.status = ST_EMPTY;
      show     = 1'b0;
    end else if (cmd == CMD_REMOVE) begin
      r.pay  = model_pay[0];
      r.prio = model_prio[0];
      for (int i = 1; i < model_held; i++) begin
        model_prio[i-1] = model_prio[i];
        model_pay[i-1]  = model_pay[i];
      end
      model_held--;
    end else begin
      r.pay  = model_pay[0];
      r.prio = model_prio[0];
    end
    if (!show) begin
      r.pay  = '0;
      r.prio = '0;
    end
    r.count = CNT_W'(model_held);
    r.empty = (model_held == 0);
    return r;
  endfunction

  task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [31:0] pay,
                         logic signed [15:0] prio, bit hold);
    cmd_item_t it;
    it.cmd  = cmd;
    it.pay  = pay;
    it.prio = prio;
    it.hold = hold;
    pending_cmds.push_back(it);
  endtask

  // Driver: record the accepted item, then hold, idle or launch the next one.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      item_taken = start && !busy;
      if (item_taken) begin
        expected_results.push_back(predict_queue_result(command, payload, priority_req));
        issued++;
      end
      if (start && !item_taken) begin
        // hold the item until the block takes it
      end else if (gap_left != 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_cmds.size() != 0 &&
                   !(pending_cmds[0].hold && expected_results.size() != 0)) begin
        nxt          = pending_cmds.pop_front();
        command      <= nxt.cmd;
        payload      <= nxt.pay;
        priority_req <= nxt.prio;
        start        <= 1'b1;
        if (burst_left != 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 10);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest prediction.
  always @(posedge clk) begin
    queue_result_t e;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with no command outstanding (status %0d)", $realtime, status);
        errors++;
      end else begin
        e = expected_results.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d, got %0d", $realtime, e.status, status);
          errors++;
        end
        if (head_payload !== e.pay) begin
          $display("%0t: head_payload expected %h, got %h", $realtime, e.pay, head_payload);
          errors++;
        end
        if (head_priority !== e.prio) begin
          $display("%0t: head_priority expected %0d, got %0d", $realtime, e.prio,
                   head_priority);
          errors++;
        end
        if (entry_count !== e.count) begin
          $display("%0t: entry_count expected %0d, got %0d", $realtime, e.count,
                   entry_count);
          errors++;
        end
        if (is_empty !== e.empty) begin
          $display("%0t: is_empty expected %0b, got %0b", $realtime, e.empty, is_empty);
          errors++;
        end
      end
    end
  end

  // Watchdog: give up when neither an item nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("%0t: watchdog expired", $realtime);
        $display("stable_sorted_priority_queue regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int phase;
    int len;
    int pick;
    bit ties;
    logic [CMD_W-1:0] c;
    logic signed [15:0] p;

    // directed: empty queue, extremes, ties in arrival order, spare code
    add_cmd(CMD_PEEK,   32'h0,        16'sd0,     1'b0);
    add_cmd(CMD_REMOVE, 32'hFFFFFFFF, -16'sd1,    1'b0);
    add_cmd(CMD_SPARE,  32'h0,        16'sd0,     1'b0);
    add_cmd(CMD_INSERT, 32'h0,        -16'sd32768, 1'b0);
    add_cmd(CMD_INSERT, 32'hFFFFFFFF, 16'sd32767, 1'b0);
    add_cmd(CMD_INSERT, 32'hA5A5A5A5, 16'sd0,     1'b0);
    add_cmd(CMD_INSERT, 32'h5A5A5A5A, 16'sd0,     1'b0);
    add_cmd(CMD_INSERT, 32'h12345678, -16'sd1,    1'b0);
    add_cmd(CMD_INSERT, 32'h00000001, 16'sd32767, 1'b0);
    add_cmd(CMD_PEEK,   32'h0,        16'sd0,     1'b0);
    add_cmd(CMD_SPARE,  32'hFFFFFFFF, -16'sd1,    1'b0);
    for (int i = 0; i < 6; i++) add_cmd(CMD_REMOVE, 32'h0, 16'sd0, 1'b0);
    add_cmd(CMD_REMOVE, 32'h0,        16'sd0,     1'b0);
    add_cmd(CMD_PEEK,   32'h0,        16'sd0,     1'b0);

    // random phases: fill, mixed, drain, mixed; some wait for the queue to settle
    phase = 0;
    while (pending_cmds.size() < 670) begin
      len  = (phase % 4 == 0) ? $urandom_range(24, 50) : $urandom_range(15, 45);
      ties = ($urandom_range(0, 1) == 1);
      for (int i = 0; i < len; i++) begin
        pick = $urandom_range(0, 99);
        case (phase % 4)
          0:       c = pick < 85 ? CMD_INSERT : (pick < 95 ? CMD_REMOVE : CMD_PEEK);
          2:       c = pick < 80 ? CMD_REMOVE : (pick < 90 ? CMD_INSERT : CMD_PEEK);
          default: c = pick < 45 ? CMD_INSERT : (pick < 85 ? CMD_REMOVE :
                       (pick < 95 ? CMD_PEEK : CMD_SPARE));
        endcase
        if (ties) p = 16'($signed($urandom_range(0, 3)) - 1);
        else      p = 16'($urandom);
        add_cmd(c, $urandom, p, i == 0 && (phase == 2 || $urandom_range(0, 2) == 0));
      end
      phase++;
    end
    total_cmds = pending_cmds.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    @(negedge clk);
    while (issued < total_cmds) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (TAIL_WAIT) @(negedge clk);

    if (errors == 0) begin
      $display("stable_sorted_priority_queue regression: pass");
    end else begin
      $display("stable_sorted_priority_queue regression: fail");
    end
    $finish;
  end

endmodule

// File: stable_sorted_priority_queue.f
+incdir+sv
sv/ssq_pkg.sv
sv/ssq_cell.sv
sv/stable_sorted_priority_queue.sv
sv/ssq_checker.sv
verif/tb_stable_sorted_priority_queue.sv
